@@ rtl/core/tlrq_pkg.sv @@
// Shared types, codes and a timestamp helper for the timestamp log range query block.
package tlrq_pkg;

	localparam int ID_W    = 16;
	localparam int STAMP_W = 40;
	localparam int GRAN_W  = 3;
	localparam int ENTRY_W = ID_W + STAMP_W;

	localparam logic CMD_PUT = 1'b0;
	localparam logic CMD_GET = 1'b1;

	localparam logic [GRAN_W-1:0] GR_ANY    = 3'd0;
	localparam logic [GRAN_W-1:0] GR_YEAR   = 3'd1;
	localparam logic [GRAN_W-1:0] GR_MONTH  = 3'd2;
	localparam logic [GRAN_W-1:0] GR_DAY    = 3'd3;
	localparam logic [GRAN_W-1:0] GR_HOUR   = 3'd4;
	localparam logic [GRAN_W-1:0] GR_MINUTE = 3'd5;
	localparam logic [GRAN_W-1:0] GR_SECOND = 3'd6;

	typedef struct packed {
		logic               cmd;
		logic [ID_W-1:0]    entry_id;
		logic [STAMP_W-1:0] entry_stamp;
		logic [STAMP_W-1:0] start_stamp;
		logic [STAMP_W-1:0] end_stamp;
		logic [GRAN_W-1:0]  granularity;
	} in_t;

	typedef struct packed {
		logic [ID_W-1:0] match_id;
		logic            found;
		logic            table_full;
		logic            last;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_FLUSH
	} state_t;

	// keep the leading fields up to the chosen granularity; unknown codes keep nothing
	function automatic logic [STAMP_W-1:0] cut_mask(input logic [GRAN_W-1:0] g);
		logic [STAMP_W-1:0] m;
		case (g)
			GR_YEAR:   m = {{14{1'b1}}, {26{1'b0}}};
			GR_MONTH:  m = {{18{1'b1}}, {22{1'b0}}};
			GR_DAY:    m = {{23{1'b1}}, {17{1'b0}}};
			GR_HOUR:   m = {{28{1'b1}}, {12{1'b0}}};
			GR_MINUTE: m = {{34{1'b1}}, {6{1'b0}}};
			GR_SECOND: m = {STAMP_W{1'b1}};
			GR_ANY:    m = '0;
			default:   m = '0;
		endcase
		return m;
	endfunction

endpackage

@@ rtl/core/tlrq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module tlrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/tlrq_cmp.sv @@
// Range compare of one stored timestamp against the cut-off query bounds.
module tlrq_cmp import tlrq_pkg::*; (
	input  logic [STAMP_W-1:0] stamp,
	input  logic [STAMP_W-1:0] mask,
	input  logic [STAMP_W-1:0] lo,
	input  logic [STAMP_W-1:0] hi,
	output logic               hit
);

	logic [STAMP_W-1:0] cut;

	assign cut = stamp & mask;
	assign hit = (cut >= lo) && (cut <= hi);

endmodule

@@ rtl/core/timestamp_log_range_query.sv @@
// Top level of the timestamp log range query block: log table, scan control, result register.
// Put: result in the cycle after the transfer; a put can be taken every cycle while not busy.
// Retrieve over N > 0 stored entries: busy through states SCAN, TAIL and FLUSH, then IDLE again;
// hits follow the table scan, one entry read per cycle; the receiver cannot stall.
// Final retrieve result is registered from FLUSH; empty table: IDLE goes straight to FLUSH.
// Reset clears the entry count and control state; table contents are not cleared.
module timestamp_log_range_query import tlrq_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  in_t  req,
	output logic busy,
	output out_t result,
	output logic valid
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

	state_t             state_q, state_d;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	logic               rd_v_s1;
	logic [STAMP_W-1:0] lo_q, hi_q, mask_q;
	logic [ID_W-1:0]    pend_id_q;
	logic               pend_v_q;
	out_t               result_q;
	logic               valid_q;

	logic               accept, is_put, is_get, has_room, wr_en, rd_en, last_issue;
	logic [ENTRY_W-1:0] rd_data;
	logic [ID_W-1:0]    rd_id;
	logic [STAMP_W-1:0] rd_stamp;
	logic               hit, take_hit;
	logic               emit_v;
	out_t               emit_d;
	logic [STAMP_W-1:0] req_mask;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign is_put     = accept && (req.cmd == CMD_PUT);
	assign is_get     = accept && (req.cmd == CMD_GET);
	assign has_room   = (count_q != FULL_COUNT);
	assign wr_en      = is_put && has_room;
	assign rd_en      = (state_q == ST_SCAN);
	assign last_issue = ((CW'(idx_q) + CW'(1)) == count_q);
	assign req_mask   = cut_mask(req.granularity);
	assign rd_id      = rd_data[ENTRY_W-1 -: ID_W];
	assign rd_stamp   = rd_data[STAMP_W-1:0];
	assign take_hit   = rd_v_s1 && hit;

	tlrq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[AW-1:0]),
		.wdata({req.entry_id, req.entry_stamp}),
		.re   (rd_en),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	tlrq_cmp u_cmp (
		.stamp(rd_stamp),
		.mask (mask_q),
		.lo   (lo_q),
		.hi   (hi_q),
		.hit  (hit)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (is_get) begin
					state_d = (count_q == '0) ? ST_FLUSH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_issue) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL:  state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit_v = 1'b0;
		emit_d = '0;
		case (state_q)
			ST_IDLE: begin
				if (is_put) begin
					emit_v            = 1'b1;
					emit_d.table_full = !has_room;
					emit_d.last       = 1'b1;
				end
			end
			ST_SCAN, ST_TAIL: begin
				if (take_hit && pend_v_q) begin
					emit_v          = 1'b1;
					emit_d.match_id = pend_id_q;
					emit_d.found    = 1'b1;
				end
			end
			ST_FLUSH: begin
				emit_v          = 1'b1;
				emit_d.match_id = pend_v_q ? pend_id_q : '0;
				emit_d.found    = pend_v_q;
				emit_d.last     = 1'b1;
			end
			default: begin
				emit_v = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			rd_v_s1  <= 1'b0;
			pend_v_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en;
			valid_q <= emit_v;
			if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
			if (is_get) begin
				idx_q    <= '0;
				pend_v_q <= 1'b0;
			end else begin
				if (rd_en) begin
					idx_q <= idx_q + AW'(1);
				end
				if (take_hit) begin
					pend_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q <= emit_d;
		if (is_get) begin
			mask_q <= req_mask;
			lo_q   <= req.start_stamp & req_mask;
			hi_q   <= req.end_stamp & req_mask;
		end
		if (take_hit) begin
			pend_id_q <= rd_id;
		end
	end

	assign result = result_q;
	assign valid  = valid_q;

endmodule

@@ rtl/core/tlrq_checker.sv @@
// Port-level assertions for the timestamp log range query block, with its bind.
module tlrq_checker import tlrq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input in_t  req,
	input logic busy,
	input out_t result,
	input logic valid
);

	a_put_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.cmd == CMD_PUT)) |=> (valid && result.last && !result.found))
		else $error("put transfer not acknowledged in the next cycle");

	a_get_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.cmd == CMD_GET)) |=> busy)
		else $error("retrieve transfer did not raise busy");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && result.table_full) |-> (result.last && !result.found && (result.match_id == '0)))
		else $error("table full flag on a non-acknowledgment result");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !result.found) |-> (result.match_id == '0) && result.last)
		else $error("result without a match carries an id or is not final");

endmodule

bind timestamp_log_range_query tlrq_checker u_tlrq_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.req   (req),
	.busy  (busy),
	.result(result),
	.valid (valid)
);

@@ dv/tlrq_checker.sv @@
`timescale 1ns / 100ps
// Checker for the timestamp log range query block: watches both channels, predicts and compares.
module tlrq_scoreboard import tlrq_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  in_t  req,
	input  out_t result,
	input  logic valid,
	output int   errors,
	output int   pending,
	output int   hits,
	output int   misses,
	output int   drops
);

	logic [ID_W-1:0]    log_ids    [$];
	logic [STAMP_W-1:0] log_stamps [$];
	int                 log_count;
	out_t               answer_q [$];
	int                 n_err, n_hit, n_miss, n_drop;

	function automatic logic [STAMP_W-1:0] trim_stamp(input logic [STAMP_W-1:0] s,
			input logic [GRAN_W-1:0] g);
		int keep;
		case (g)
			GR_YEAR:   keep = 14;
			GR_MONTH:  keep = 18;
			GR_DAY:    keep = 23;
			GR_HOUR:   keep = 28;
			GR_MINUTE: keep = 34;
			GR_SECOND: keep = 40;
			default:   keep = 0;
		endcase
		return s >> (STAMP_W - keep);
	endfunction

	task automatic add_answer(input out_t r);
		answer_q.insert(answer_q.size(), r);
	endtask

	task automatic predict_command(input in_t item);
		out_t r;
		int   i;
		int   n;
		logic hit;
		n = 0;
		r = '0;
		if (item.cmd == CMD_PUT) begin
			r.last = 1'b1;
			if (log_count < MAX_ENTRIES) begin
				log_ids.insert(log_count, item.entry_id);
				log_stamps.insert(log_count, item.entry_stamp);
				log_count++;
			end else begin
				r.table_full = 1'b1;
			end
			add_answer(r);
		end else begin
			for (i = 0; i < log_count; i++) begin
				case (item.granularity)
					GR_YEAR, GR_MONTH, GR_DAY, GR_HOUR, GR_MINUTE, GR_SECOND:
						hit = trim_stamp(log_stamps[i], item.granularity) >=
								trim_stamp(item.start_stamp, item.granularity) &&
							trim_stamp(log_stamps[i], item.granularity) <=
								trim_stamp(item.end_stamp, item.granularity);
					default: hit = 1'b1;
				endcase
				if (hit) begin
					r          = '0;
					r.match_id = log_ids[i];
					r.found    = 1'b1;
					add_answer(r);
					n++;
				end
			end
			if (n == 0) begin
				r      = '0;
				r.last = 1'b1;
				add_answer(r);
			end else begin
				r      = answer_q.pop_back();
				r.last = 1'b1;
				add_answer(r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			log_count = 0;
			log_ids.delete();
			log_stamps.delete();
			answer_q.delete();
		end else begin
			if (valid) begin
				if (answer_q.size() == 0) begin
					if (n_err < 10)
						$display("%0t: unexpected result id=%h found=%b full=%b last=%b", $time,
							result.match_id, result.found, result.table_full, result.last);
					n_err++;
				end else begin
					want = answer_q.pop_front();
					if (result.match_id !== want.match_id || result.found !== want.found ||
							result.table_full !== want.table_full || result.last !== want.last) begin
						if (n_err < 10)
							$display("%0t: mismatch: expected id=%h found=%b full=%b last=%b",
								$time, want.match_id, want.found, want.table_full, want.last,
								", got id=%h found=%b full=%b last=%b",
								result.match_id, result.found, result.table_full, result.last);
						n_err++;
					end
					if (want.table_full)
						n_drop++;
					else if (want.found)
						n_hit++;
				end
			end
			if (start && !busy) begin
				predict_command(req);
				if (req.cmd == CMD_GET && answer_q.size() > 0 && !answer_q[$].found)
					n_miss++;
			end
		end
		errors  <= n_err;
		pending <= answer_q.size();
		hits    <= n_hit;
		misses  <= n_miss;
		drops   <= n_drop;
	end

endmodule

@@ dv/tb_timestamp_log_range_query.sv @@
`timescale 1ns / 100ps
// Testbench top for the timestamp log range query block: stimulus, watchdog and verdict.
module tb_timestamp_log_range_query;
	import tlrq_pkg::*;

	localparam int MAX_ENTRIES  = 64;
	localparam int RANDOM_ITEMS = 60;
	localparam int SCAN_LATENCY = MAX_ENTRIES + 3;
	localparam int STALL_LIMIT  = 1000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic valid;
	in_t  req;
	out_t result;

	int errors, pending, hits, misses, drops;
	int puts_sent, gets_sent, quiet_cycles;
	bit [STAMP_W-1:0] recent_stamps [8];

	timestamp_log_range_query #(.MAX_ENTRIES(MAX_ENTRIES)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.result (result),
		.valid  (valid)
	);

	tlrq_scoreboard #(.MAX_ENTRIES(MAX_ENTRIES)) u_scoreboard (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.result  (result),
		.valid   (valid),
		.errors  (errors),
		.pending (pending),
		.hits    (hits),
		.misses  (misses),
		.drops   (drops)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, pending);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [STAMP_W-1:0] rand40();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[STAMP_W-1:0];
	endfunction

	function automatic logic [STAMP_W-1:0] stamp_of(input logic [13:0] yr, input logic [3:0] mo,
			input logic [4:0] dy, input logic [4:0] hr, input logic [5:0] mi, input logic [5:0] se);
		return {yr, mo, dy, hr, mi, se};
	endfunction

	function automatic logic [STAMP_W-1:0] rand_stamp();
		logic [13:0] yr;
		case ($urandom_range(0, 5))
			0, 1:    yr = 14'd2024;
			2:       yr = 14'd2025;
			3:       yr = '1;
			4:       yr = '0;
			default: return rand40();
		endcase
		return stamp_of(yr, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
			5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
	endfunction

	function automatic in_t make_put(input logic [ID_W-1:0] id, input logic [STAMP_W-1:0] stamp);
		in_t item;
		item.cmd         = CMD_PUT;
		item.entry_id    = id;
		item.entry_stamp = stamp;
		item.start_stamp = rand40();
		item.end_stamp   = rand40();
		item.granularity = 3'($urandom_range(0, 7));
		return item;
	endfunction

	function automatic in_t make_get(input logic [STAMP_W-1:0] lo, input logic [STAMP_W-1:0] hi,
			input logic [GRAN_W-1:0] g);
		in_t item;
		item.cmd         = CMD_GET;
		item.entry_id    = 16'($urandom_range(0, 65535));
		item.entry_stamp = rand40();
		item.start_stamp = lo;
		item.end_stamp   = hi;
		item.granularity = g;
		return item;
	endfunction

	// hold start until the transfer edge; start stays high for a following item
	task automatic issue(input in_t item);
		start <= 1'b1;
		req   <= item;
		do @(posedge clk); while (busy);
		if (item.cmd == CMD_PUT) begin
			recent_stamps[puts_sent[2:0]] = item.entry_stamp;
			puts_sent++;
		end else begin
			gets_sent++;
		end
	endtask

	task automatic maybe_idle(input bit allowed);
		if (allowed && $urandom_range(0, 99) < 36) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic quiesce();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic in_t rand_get();
		logic [STAMP_W-1:0] pick, lo, hi, tmp;
		pick = recent_stamps[3'($urandom_range(0, 7))];
		case ($urandom_range(0, 3))
			0: begin
				lo = pick & ~40'hFFF;
				hi = pick | 40'hFFF;
			end
			1: begin
				lo = pick & ~40'h1FFFF;
				hi = pick | 40'h1FFFF;
			end
			2: begin
				lo = rand_stamp();
				hi = rand_stamp();
				if (lo > hi) begin
					tmp = lo;
					lo  = hi;
					hi  = tmp;
				end
			end
			default: begin
				lo = rand_stamp();
				hi = rand_stamp();
			end
		endcase
		return make_get(lo, hi, 3'($urandom_range(0, 7)));
	endfunction

	initial begin
		in_t                item;
		logic [STAMP_W-1:0] lo, hi;
		int                 i, g;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(make_get('0, '1, GR_ANY));
		issue(make_get('0, '1, GR_SECOND));
		issue(make_put(16'h0000, '0));
		issue(make_put(16'hFFFF, '1));
		issue(make_put(16'h1234, stamp_of(14'd2024, 4'd3, 5'd15, 5'd10, 6'd30, 6'd45)));
		issue(make_put(16'h1235, stamp_of(14'd2024, 4'd3, 5'd15, 5'd10, 6'd31, 6'd0)));
		issue(make_put(16'h1236, stamp_of(14'd2024, 4'd4, 5'd1, 5'd0, 6'd0, 6'd0)));
		issue(make_put(16'h1237, stamp_of(14'd2025, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0)));
		issue(make_get(rand40(), rand40(), GR_ANY));
		issue(make_get(rand40(), rand40(), '1));
		lo = stamp_of(14'd2024, 4'd3, 5'd15, 5'd10, 6'd30, 6'd50);
		hi = stamp_of(14'd2024, 4'd3, 5'd15, 5'd10, 6'd31, 6'd0);
		issue(make_get(lo, hi, GR_YEAR));
		issue(make_get(lo, hi, GR_MONTH));
		issue(make_get(lo, hi, GR_DAY));
		issue(make_get(lo, hi, GR_HOUR));
		issue(make_get(lo, hi, GR_MINUTE));
		issue(make_get(lo, hi, GR_SECOND));
		issue(make_get(stamp_of(14'd2025, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0), lo, GR_YEAR));
		issue(make_get(stamp_of(14'd2025, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0), lo, GR_ANY));
		issue(make_get('0, '1, GR_SECOND));
		issue(make_get('1, '1, GR_SECOND));
		item             = make_put(16'hA5A5, 40'h5A5A5A5A5A);
		item.start_stamp = '1;
		item.end_stamp   = '1;
		item.granularity = '1;
		issue(item);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			maybe_idle(i < 20 || i >= 45);
			if (i == RANDOM_ITEMS / 2)
				quiesce();
			if ($urandom_range(0, 99) < 65)
				issue(make_put(16'($urandom_range(0, 65535)), rand_stamp()));
			else
				issue(rand_get());
		end

		while (puts_sent < MAX_ENTRIES + 3) begin
			maybe_idle(1'b1);
			issue(make_put(16'($urandom_range(0, 65535)), rand_stamp()));
		end
		for (g = 0; g < 8; g++) begin
			maybe_idle(1'b1);
			item             = rand_get();
			item.granularity = g[GRAN_W-1:0];
			issue(item);
		end

		quiesce();
		repeat (SCAN_LATENCY) @(posedge clk);

		$display("run covered %0d puts, %0d of them dropped on a full table, and %0d retrieves",
			puts_sent, drops, gets_sent);
		$display("retrieves returned %0d matching ids and %0d answered with no match",
			hits, misses);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
